FILE: rtl/sabm_pkg.sv
package sabm_pkg;

  // Store geometry: one mark per 1 MB section, held as rows of marks.
  localparam int MAX_SECTIONS  = 512;
  localparam int ROW_W         = 64;
  localparam int BIT_W         = $clog2(ROW_W);
  localparam int ROWS          = MAX_SECTIONS / ROW_W;
  localparam int ROW_AW        = $clog2(ROWS);
  localparam int IDX_W         = $clog2(MAX_SECTIONS);
  localparam int CNT_W         = $clog2(MAX_SECTIONS + 1);

  // Field widths of the words on the ports.
  localparam int KIND_W        = 2;
  localparam int SEC_W         = 9;
  localparam int CFG_W         = 9;
  localparam int ADDR_W        = 32;
  localparam int STATUS_W      = 3;
  localparam int IN_DATA_W     = 48;
  localparam int OUT_DATA_W    = 16;

  // Address map.
  localparam int SECTION_SHIFT = 20;
  localparam int CMP_W         = ADDR_W - SECTION_SHIFT + 1;
  localparam logic [ADDR_W-1:0] DEVICE_BASE = 32'h2000_0000;
  localparam logic [CFG_W-1:0]  NUM_SECTIONS_RESET = 9'd150;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ALLOC_ANY   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC_EXACT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE        = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY       = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NONE_FREE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL   = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic eval;
    logic out_load;
  } sabm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more;
  } sabm_stat_t;

endpackage

FILE: rtl/sabm_ram.sv
module sabm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sabm_datapath.sv
module sabm_datapath import sabm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  sabm_cmd_t             cmd,
  output sabm_stat_t            stat,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [SEC_W-1:0]      in_section,
  input  logic [ADDR_W-1:0]     in_addr,
  input  logic [CFG_W-1:0]      num_sections,
  output logic [OUT_DATA_W-1:0] out_data
);

  // Request registers.
  logic [KIND_W-1:0]   kind;
  logic [IDX_W-1:0]    sec;
  logic                dev;
  logic                illegal;
  logic [CNT_W-1:0]    count;
  logic [ROW_AW-1:0]   row;
  logic [ROWS-1:0]     row_valid;

  // Result registers.
  logic [IDX_W-1:0]    res_index;
  logic [STATUS_W-1:0] res_status;
  logic                res_alloc;

  // Decode of an incoming word.
  logic [CMP_W-1:0]    in_sel;
  logic [CNT_W-1:0]    in_count;
  logic [IDX_W-1:0]    in_sec;

  // Evaluation of one row.
  logic [ROW_W-1:0]    rdata;
  logic [ROW_W-1:0]    word;
  logic [ROW_W-1:0]    usable;
  logic [ROW_W-1:0]    free_vec;
  logic [BIT_W-1:0]    first;
  logic                any_free;
  logic [BIT_W-1:0]    bit_pos;
  logic [ROW_W-1:0]    bit_mask;
  logic                hit;
  logic [CNT_W-1:0]    base_next;
  logic                wr_en;
  logic [ROW_W-1:0]    wr_data;
  logic [IDX_W-1:0]    r_index;
  logic [STATUS_W-1:0] r_status;
  logic                r_alloc;

  // The section a request names, and whether it lies inside the usable count.
  always_comb begin
    in_count = (CMP_W'(num_sections) > CMP_W'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS)
                                                               : CNT_W'(num_sections);
    in_sel   = (in_kind == KIND_QUERY) ? CMP_W'(in_addr >> SECTION_SHIFT)
                                       : CMP_W'(in_section);
    in_sec   = IDX_W'(in_sel);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind    <= in_kind;
      sec     <= in_sec;
      dev     <= (in_addr >= DEVICE_BASE);
      illegal <= (in_sel >= CMP_W'(in_count));
      count   <= in_count;
    end
  end

  // Row pointer: the named row, or a walk upwards from row zero for first fit.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row <= (in_kind == KIND_ALLOC_ANY) ? '0 : in_sec[IDX_W-1:BIT_W];
    end else if (cmd.eval && stat.more) begin
      row <= row + ROW_AW'(1);
    end
  end

  // A row never written since reset reads as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.eval && wr_en) begin
      row_valid[row] <= 1'b1;
    end
  end

  sabm_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ROWS)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.eval && wr_en),
    .waddr(row),
    .wdata(wr_data),
    .raddr(row),
    .rdata(rdata)
  );

  // Marks of the current row, limited to sections below the count.
  always_comb begin
    word = row_valid[row] ? rdata : '0;
    for (int j = 0; j < ROW_W; j++) begin
      usable[j] = CNT_W'({row, BIT_W'(j)}) < count;
    end
    free_vec = ~word & usable;
    any_free = |free_vec;
    first    = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (free_vec[j]) begin
        first = BIT_W'(j);
      end
    end
    bit_pos   = sec[BIT_W-1:0];
    bit_mask  = ROW_W'(1) << bit_pos;
    hit       = word[bit_pos];
    base_next = (CNT_W'(row) + CNT_W'(1)) << BIT_W;
  end

  assign stat.more = (kind == KIND_ALLOC_ANY) && !any_free && (base_next < count);

  // Outcome of the request against the current row.
  always_comb begin
    wr_en    = 1'b0;
    wr_data  = word;
    r_index  = '0;
    r_status = ST_OK;
    r_alloc  = 1'b0;
    unique case (kind)
      KIND_ALLOC_ANY: begin
        if (any_free) begin
          wr_en   = 1'b1;
          wr_data = word | (ROW_W'(1) << first);
          r_index = {row, first};
        end else begin
          r_status = ST_NONE_FREE;
        end
      end
      KIND_ALLOC_EXACT: begin
        if (illegal) begin
          r_status = ST_ILLEGAL;
        end else if (hit) begin
          r_status = ST_ALREADY;
        end else begin
          wr_en   = 1'b1;
          wr_data = word | bit_mask;
        end
      end
      KIND_FREE: begin
        if (illegal) begin
          r_status = ST_ILLEGAL;
        end else if (!hit) begin
          r_status = ST_NOT_ALLOC;
        end else begin
          wr_en   = 1'b1;
          wr_data = word & ~bit_mask;
        end
      end
      default: begin
        if (dev) begin
          r_alloc = 1'b1;
        end else if (illegal) begin
          r_status = ST_ILLEGAL;
        end else begin
          r_alloc = hit;
        end
      end
    endcase
  end

  // Result held until the output register is free.
  always_ff @(posedge clk) begin
    if (cmd.eval && !stat.more) begin
      res_index  <= r_index;
      res_status <= r_status;
      res_alloc  <= r_alloc;
    end
  end

  // Output register: index, status, allocated flag, references left.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {2'b00, 1'b0, res_alloc, res_status, SEC_W'(res_index)};
    end
  end

endmodule

FILE: rtl/sabm_ctrl.sv
module sabm_ctrl import sabm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output sabm_cmd_t  cmd,
  input  sabm_stat_t stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       m_tvalid_next;

  assign s_tready     = (state == S_IDLE);
  assign cmd.accept   = s_tready && s_tvalid;
  assign cmd.eval     = (state == S_EVAL);
  assign cmd.out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // Sequencer: read a row, evaluate it, repeat while first fit walks on.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = stat.more ? S_READ : S_DONE;
      end
      S_DONE: begin
        if (cmd.out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid: set when a result moves in, cleared when it is taken.
  always_comb begin
    if (cmd.out_load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

FILE: rtl/section_bitmap_allocator.sv
// An accepted word is registered, its row is read from the RAM and evaluated,
// and the result is loaded into the output register; allocate-any reads and
// evaluates each further row of 64 marks that it walks before its result.
// One request at a time: no new word is taken before the last result is loaded.
// Reset clears the section marks through per-row valid bits and
// sets the section count to 150; no clearing pass is needed.
module section_bitmap_allocator import sabm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // section[8:0], phys_addr[40:9]
  input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // section_index[8:0], status[11:9],
                                           // is_allocated[12], refs_left[13]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data   // num_sections[8:0]
);

  logic [CFG_W-1:0] num_sections;
  sabm_cmd_t        cmd;
  sabm_stat_t       stat;

  // Section count register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_sections <= NUM_SECTIONS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_sections <= cfg_data;
    end
  end

  sabm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd),
    .stat    (stat)
  );

  sabm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_kind     (s_tuser),
    .in_section  (s_tdata[SEC_W-1:0]),
    .in_addr     (s_tdata[SEC_W+ADDR_W-1:SEC_W]),
    .num_sections(num_sections),
    .out_data    (m_tdata)
  );

endmodule

FILE: rtl/sabm_checker.sv
module sabm_checker import sabm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A stalled result word stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Status is one of the defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:9] == ST_OK) || (m_tdata[11:9] == ST_NONE_FREE) ||
                 (m_tdata[11:9] == ST_ALREADY) || (m_tdata[11:9] == ST_NOT_ALLOC) ||
                 (m_tdata[11:9] == ST_ILLEGAL))
    else $error("undefined status code");

  // The references-left flag is never set in a result word.
  a_refs_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13] == 1'b0))
    else $error("refs_left set");

  // A section index or an allocated answer comes only with an ok status.
  a_index_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tdata[8:0] != 9'd0) || m_tdata[12]) |-> (m_tdata[11:9] == ST_OK))
    else $error("index or allocated flag with failing status");

  // No new request is taken while a word is still being worked on.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted back to back");

endmodule

bind section_bitmap_allocator sabm_checker u_sabm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: bench/section_bitmap_checker.sv
module section_bitmap_checker import sabm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // section[8:0], phys_addr[40:9]
  input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // section_index[8:0], status[11:9],
                                           // is_allocated[12], refs_left[13]
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data,  // num_sections[8:0]
  output int unsigned           mismatches,
  output int unsigned           results_due
);

  // One result word, laid out as it sits in the low bits of m_tdata.
  typedef struct packed {
    logic                refs_left;
    logic                is_allocated;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    section_index;
  } alloc_result_t;

  localparam int RESULT_W = $bits(alloc_result_t);

  logic [MAX_SECTIONS-1:0] section_used;
  logic [CFG_W-1:0]        section_limit;
  alloc_result_t           due_results[$];

  // Serve one request against the shadow bitmap and return what the block should answer.
  function automatic alloc_result_t serve_request(logic [KIND_W-1:0] kind,
                                                  logic [SEC_W-1:0] section,
                                                  logic [ADDR_W-1:0] addr);
    alloc_result_t res;
    int            usable;
    int            addr_section;
    res    = '0;
    usable = (section_limit > MAX_SECTIONS) ? MAX_SECTIONS : int'(section_limit);
    case (kind)
      KIND_ALLOC_ANY: begin
        res.status = ST_NONE_FREE;
        for (int i = 0; i < usable; i++) begin
          if (!section_used[i[IDX_W-1:0]]) begin
            section_used[i[IDX_W-1:0]] = 1'b1;
            res.section_index = i[IDX_W-1:0];
            res.status        = ST_OK;
            break;
          end
        end
      end
      KIND_ALLOC_EXACT: begin
        if (section >= usable) res.status = ST_ILLEGAL;
        else if (section_used[section]) res.status = ST_ALREADY;
        else section_used[section] = 1'b1;
      end
      KIND_FREE: begin
        if (section >= usable) res.status = ST_ILLEGAL;
        else if (!section_used[section]) res.status = ST_NOT_ALLOC;
        else section_used[section] = 1'b0;
      end
      default: begin
        // Device space always reads as taken; RAM addresses look up their section.
        if (addr >= DEVICE_BASE) begin
          res.is_allocated = 1'b1;
        end else begin
          addr_section = int'(addr >> SECTION_SHIFT);
          if (addr_section >= usable) res.status = ST_ILLEGAL;
          else res.is_allocated = section_used[addr_section[IDX_W-1:0]];
        end
      end
    endcase
    return res;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Track configuration, queue predictions on accepted requests and check results in order.
  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    if (rst) begin
      section_used  = '0;
      section_limit = NUM_SECTIONS_RESET;
      due_results.delete();
      mismatches    = 0;
      results_due  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) section_limit = cfg_data;
      if (m_tvalid && m_tready) begin
        got = alloc_result_t'(m_tdata[RESULT_W-1:0]);
        if (due_results.size() == 0) begin
          $error("result word arrived with no request outstanding");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("section_index", 32'(want.section_index), 32'(got.section_index));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("is_allocated", 32'(want.is_allocated), 32'(got.is_allocated));
          check_field("refs_left", 32'(want.refs_left), 32'(got.refs_left));
        end
      end
      if (s_tvalid && s_tready)
        due_results.push_back(serve_request(s_tuser, s_tdata[SEC_W-1:0],
                                            s_tdata[SEC_W+ADDR_W-1:SEC_W]));
      results_due <= due_results.size();
    end
  end

endmodule

FILE: bench/tb.sv
module tb import sabm_pkg::*; ();

  localparam int SETTLE_CYCLES  = 24;
  localparam int STALL_LIMIT    = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_REQUESTS = 190;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [KIND_W-1:0]     s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;
  int unsigned           mismatches;
  int unsigned           results_due;
  int unsigned           quiet_cycles;
  bit                    no_idle;
  bit                    hold_request;

  section_bitmap_allocator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  section_bitmap_checker u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .results_due(results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one request word after a random gap and hold it until it is taken.
  task automatic send_request(logic [KIND_W-1:0] kind, logic [SEC_W-1:0] section,
                              logic [ADDR_W-1:0] addr);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(IN_DATA_W - SEC_W - ADDR_W){1'b0}}, addr, section};
    do @(posedge clk); while (!s_tready);
  endtask

  // A random request, mostly aimed at the usable sections so that the bitmap fills and drains.
  task automatic send_random(int usable);
    logic [KIND_W-1:0] kind;
    logic [SEC_W-1:0]  section;
    logic [ADDR_W-1:0] addr;
    int                pick;
    pick = $urandom_range(0, 99);
    kind = (pick < 30) ? KIND_ALLOC_ANY : (pick < 50) ? KIND_ALLOC_EXACT :
           (pick < 75) ? KIND_FREE : KIND_QUERY;
    if (usable == 0 || $urandom_range(0, 4) == 0) section = SEC_W'($urandom);
    else section = SEC_W'($urandom_range(0, usable - 1));
    if ($urandom_range(0, 3) == 0) addr = $urandom;
    else addr = ({23'd0, section} << SECTION_SHIFT) | ($urandom & 32'h000F_FFFF);
    send_request(kind, section, addr);
  endtask

  // Change the section count once every outstanding result has come back.
  task automatic write_count(logic [CFG_W-1:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random back-pressure per word, with the odd long hold-off.
  initial begin
    int stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus: directed corner cases, then random phases over several section counts.
  initial begin
    int phase_counts[$];
    int usable;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= KIND_ALLOC_ANY;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset count of 150: section 0 before and after allocation, edges of the range.
    send_request(KIND_QUERY, '0, 32'h0000_0000);
    send_request(KIND_ALLOC_ANY, '0, '0);
    send_request(KIND_QUERY, '0, 32'h000F_FFFF);
    send_request(KIND_ALLOC_EXACT, 9'd0, '0);
    send_request(KIND_ALLOC_EXACT, 9'd149, '0);
    send_request(KIND_ALLOC_EXACT, 9'd150, '0);
    send_request(KIND_ALLOC_EXACT, 9'd511, '0);
    send_request(KIND_QUERY, '0, 32'd149 << SECTION_SHIFT);
    send_request(KIND_FREE, 9'd149, '0);
    send_request(KIND_FREE, 9'd149, '0);
    send_request(KIND_FREE, 9'd511, '0);
    send_request(KIND_QUERY, '0, 32'h1FFF_FFFF);
    send_request(KIND_QUERY, '0, 32'd150 << SECTION_SHIFT);
    send_request(KIND_QUERY, '0, DEVICE_BASE);
    send_request(KIND_QUERY, '0, 32'hFFFF_FFFF);
    send_request(KIND_ALLOC_EXACT, 9'd100, '0);

    // No usable sections at all.
    write_count(9'd0);
    send_request(KIND_ALLOC_ANY, '0, '0);
    send_request(KIND_ALLOC_EXACT, 9'd0, '0);
    send_request(KIND_FREE, 9'd0, '0);
    send_request(KIND_QUERY, '0, 32'h0000_0000);
    send_request(KIND_QUERY, '0, DEVICE_BASE);

    // One section, already taken: allocate-any finds none free until it is released.
    write_count(9'd1);
    send_request(KIND_ALLOC_ANY, '0, '0);
    send_request(KIND_FREE, 9'd0, '0);
    send_request(KIND_ALLOC_ANY, '0, '0);

    // Shrinking below a mark hides it; raising the count again brings it back.
    write_count(9'd50);
    send_request(KIND_QUERY, '0, 32'd100 << SECTION_SHIFT);
    write_count(9'd511);
    send_request(KIND_QUERY, '0, 32'd100 << SECTION_SHIFT);
    send_request(KIND_ALLOC_EXACT, 9'd510, '0);
    send_request(KIND_QUERY, '0, 32'd510 << SECTION_SHIFT);
    send_request(KIND_FREE, 9'd510, '0);

    phase_counts = '{150, 511, 1, 2, 64, 65, 0, $urandom_range(3, 510), 300};
    foreach (phase_counts[p]) begin
      usable = phase_counts[p];
      write_count(usable[CFG_W-1:0]);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (n == 20 && (p == 0 || p == 4)) hold_request = 1'b1;
        send_random(usable);
      end
    end

    // Drain, let the block settle, then give the verdict.
    no_idle = 1'b0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
